/* rtl/lpcs_pkg.sv */
package lpcs_pkg;

    localparam int LED_COUNT_DEFAULT = 32;
    localparam int SEQ_LAST = 33;
    localparam int TABLE_ROWS = 17;
    localparam int TIMER_DIV = 20;
    localparam int DELAY_SPREAD = 100;

    // floor(x / DELAY_SPREAD) for 16-bit x, low by at most one
    localparam int RECIP_SPREAD = 655;
    localparam int RECIP_SPREAD_SHIFT = 16;
    // exact floor(x / TIMER_DIV) for 8-bit x
    localparam int RECIP_DIV = 205;
    localparam int RECIP_DIV_SHIFT = 12;

    localparam logic [15:0] SEED_DEFAULT = 16'd44257;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] REFRESH_DEFAULT = 16'd20;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_REFRESH = 2'd1,
        CFG_SEED    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] value;
        logic [7:0] delay_lo;
        logic [7:0] delay_hi;
    } color_row_t;

    typedef struct packed {
        logic [5:0] step;
        logic [7:0] timer;
    } led_entry_t;

    function automatic color_row_t color_row(input logic [4:0] row);
        color_row_t r;
        unique case (row)
            5'd0:    r = '{8'd87, 8'd0, 8'd0, 8'd100, 8'd200};
            5'd1:    r = '{8'd87, 8'd52, 8'd26, 8'd25, 8'd25};
            5'd2:    r = '{8'd87, 8'd103, 8'd53, 8'd25, 8'd25};
            5'd3:    r = '{8'd87, 8'd155, 8'd79, 8'd25, 8'd25};
            5'd4:    r = '{8'd87, 8'd206, 8'd105, 8'd100, 8'd200};
            5'd5:    r = '{8'd85, 8'd218, 8'd125, 8'd25, 8'd25};
            5'd6:    r = '{8'd83, 8'd231, 8'd145, 8'd25, 8'd25};
            5'd7:    r = '{8'd81, 8'd243, 8'd164, 8'd25, 8'd25};
            5'd8:    r = '{8'd79, 8'd255, 8'd184, 8'd100, 8'd200};
            5'd9:    r = '{8'd64, 8'd255, 8'd201, 8'd25, 8'd25};
            5'd10:   r = '{8'd49, 8'd255, 8'd217, 8'd25, 8'd25};
            5'd11:   r = '{8'd33, 8'd255, 8'd234, 8'd25, 8'd25};
            5'd12:   r = '{8'd18, 8'd255, 8'd250, 8'd100, 8'd200};
            5'd13:   r = '{8'd14, 8'd255, 8'd241, 8'd25, 8'd25};
            5'd14:   r = '{8'd9, 8'd255, 8'd232, 8'd25, 8'd25};
            5'd15:   r = '{8'd5, 8'd255, 8'd223, 8'd25, 8'd25};
            5'd16:   r = '{8'd0, 8'd255, 8'd214, 8'd200, 8'd200};
            default: r = '0;
        endcase
        return r;
    endfunction

    // forward then back through the table, clamped to the last row
    function automatic logic [4:0] mirror_row(input logic [5:0] s);
        logic [5:0] r;
        r = (s <= 6'(TABLE_ROWS)) ? s : 6'(6'(SEQ_LAST) - s);
        if (r > 6'(TABLE_ROWS - 1))
        begin
            r = 6'(TABLE_ROWS - 1);
        end
        return r[4:0];
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] n;
        n = v >> 1;
        if (v[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

/* rtl/lpcs_tick_if.sv */
interface lpcs_tick_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink (input valid, input now_ms, output ready);
endinterface

/* rtl/lpcs_color_if.sv */
interface lpcs_color_if;
    logic       valid;
    logic       ready;
    logic [4:0] led_index;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness_value;
    logic       advanced;
    logic       last_of_frame;

    modport source (
        output valid, output led_index, output hue, output saturation,
        output brightness_value, output advanced, output last_of_frame,
        input ready
    );
    modport sink (
        input valid, input led_index, input hue, input saturation,
        input brightness_value, input advanced, input last_of_frame,
        output ready
    );
endinterface

/* rtl/lpcs_led_store.sv */
module lpcs_led_store #(
    parameter int DEPTH = lpcs_pkg::LED_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  lpcs_pkg::led_entry_t              wr_data,
    input  logic                              rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output lpcs_pkg::led_entry_t              rd_data
);

    lpcs_pkg::led_entry_t mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    lpcs_pkg::led_entry_t rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // never-written entries read as the reset state
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/led_pingpong_color_sequencer.sv */
// channel   dir   payload                                        transfer
// tick      in    now_ms                                         valid & ready
// color     out   led_index, hue, saturation, brightness_value,  valid & ready
//                 advanced, last_of_frame
// cfg       in    cfg_index, cfg_data                            cfg_we
//
// an accepted tick passes a setup state that reads the first led's state, then
// the walk visits every led in order through the state memory read port
// a led that reloads from the random spread right after another one waits
// while the lfsr remainder is recomputed
// ignored ticks are dropped; color stalls hold the led walk, and the tick input
// waits until the walk is done
// reset clears the led states through per-entry valid bits, no clearing pass
module led_pingpong_color_sequencer #(
    parameter int LED_COUNT = lpcs_pkg::LED_COUNT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lpcs_tick_if.sink                          tick,
    lpcs_color_if.source                       color,
    input  logic                               cfg_we,
    input  logic [lpcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lpcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW-1:0] LAST_LED = AW'(LED_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } state_t;

    state_t      state_reg;
    logic        enable_reg;
    logic [15:0] refresh_reg;
    logic [15:0] lfsr_reg;
    logic [31:0] last_tick_reg;
    logic [7:0]  delta_lo_reg;
    logic        delta_big_reg;
    logic [3:0]  dec_reg;
    logic [9:0]  qn_reg;
    logic        qn_ok_reg;
    logic [AW-1:0] led_reg;

    logic        out_valid_reg;
    logic [4:0]  out_index_reg;
    logic [7:0]  out_hue_reg;
    logic [7:0]  out_sat_reg;
    logic [7:0]  out_val_reg;
    logic        out_adv_reg;
    logic        out_last_reg;

    logic [31:0] delta;
    logic        tick_take;
    logic        tick_ok;
    logic [15:0] lfsr_nxt;
    logic [25:0] qn_prod;
    logic [15:0] dec_prod;
    logic [16:0] rem_wide;
    logic [7:0]  rem_lo;
    logic [6:0]  rem;

    lpcs_pkg::led_entry_t entry;
    lpcs_pkg::led_entry_t entry_next;
    lpcs_pkg::color_row_t row_data;
    logic [5:0]  step_adv;
    logic [5:0]  step_hold;
    logic [4:0]  row;
    logic        adv;
    logic        need_rand;
    logic        out_free;
    logic        fire;
    logic        lfsr_we;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]  reload;

    assign delta     = tick.now_ms - last_tick_reg;
    assign tick.ready = (state_reg == ST_IDLE);
    assign tick_take = tick.valid && tick.ready;
    assign tick_ok   = enable_reg && (delta >= {16'b0, refresh_reg});

    assign lfsr_nxt = lpcs_pkg::lfsr_step(lfsr_reg);
    assign qn_prod  = {10'b0, lfsr_nxt} * 26'(lpcs_pkg::RECIP_SPREAD);
    assign dec_prod = {8'b0, delta_lo_reg} * 16'(lpcs_pkg::RECIP_DIV);

    // remainder of the next lfsr value by the delay spread
    assign rem_wide = {1'b0, lfsr_nxt} - 17'({7'b0, qn_reg} * 17'(lpcs_pkg::DELAY_SPREAD));
    assign rem_lo   = rem_wide[7:0];
    assign rem      = (rem_lo >= 8'(lpcs_pkg::DELAY_SPREAD))
                      ? 7'(rem_lo - 8'(lpcs_pkg::DELAY_SPREAD)) : rem_lo[6:0];

    always_comb
    begin
        adv       = delta_big_reg || (delta_lo_reg > entry.timer);
        step_adv  = (entry.step >= 6'(lpcs_pkg::SEQ_LAST)) ? 6'd0 : 6'(entry.step + 6'd1);
        step_hold = (entry.step <= 6'(lpcs_pkg::SEQ_LAST)) ? entry.step : 6'd0;
        row       = lpcs_pkg::mirror_row(adv ? step_adv : step_hold);
        row_data  = lpcs_pkg::color_row(row);
        need_rand = adv && (row_data.delay_hi != row_data.delay_lo);
        reload    = 8'({1'b0, row_data.delay_lo} + (need_rand ? {2'b0, rem} : 9'd0));
        if (adv)
        begin
            entry_next.step  = step_adv;
            entry_next.timer = reload;
        end
        else
        begin
            entry_next.step  = entry.step;
            entry_next.timer = entry.timer - {4'b0, dec_reg};
        end
    end

    assign out_free = !out_valid_reg || color.ready;
    assign fire     = (state_reg == ST_RUN) && out_free && !(need_rand && !qn_ok_reg);
    assign lfsr_we  = fire && need_rand;
    assign rd_en    = (state_reg == ST_PREP) || (fire && (led_reg != LAST_LED));
    assign rd_addr  = (state_reg == ST_PREP) ? '0 : AW'(led_reg + AW'(1));

    lpcs_led_store #(
        .DEPTH (LED_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire),
        .wr_addr (led_reg),
        .wr_data (entry_next),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b1;
            refresh_reg   <= lpcs_pkg::REFRESH_DEFAULT;
            lfsr_reg      <= lpcs_pkg::SEED_DEFAULT;
            last_tick_reg <= '0;
            qn_ok_reg     <= 1'b0;
            led_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lpcs_pkg::CFG_ENABLE:  enable_reg  <= cfg_data[0];
                    lpcs_pkg::CFG_REFRESH: refresh_reg <= cfg_data;
                    lpcs_pkg::CFG_SEED:    lfsr_reg    <= (cfg_data != '0)
                                                          ? cfg_data
                                                          : lpcs_pkg::SEED_DEFAULT;
                    default: ;
                endcase
            end
            else if (lfsr_we)
            begin
                lfsr_reg <= lfsr_nxt;
            end

            qn_ok_reg <= !lfsr_we && !cfg_we;

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (color.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (tick_take && tick_ok)
                    begin
                        last_tick_reg <= tick.now_ms;
                        state_reg     <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    led_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (fire)
                    begin
                        if (led_reg == LAST_LED)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            led_reg <= AW'(led_reg + AW'(1));
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg <= qn_prod[25:16];
        if (tick_take)
        begin
            delta_lo_reg  <= delta[7:0];
            delta_big_reg <= |delta[31:8];
        end
        if (state_reg == ST_PREP)
        begin
            dec_reg <= dec_prod[15:12];
        end
        if (fire)
        begin
            out_index_reg <= 5'(led_reg);
            out_hue_reg   <= row_data.hue;
            out_sat_reg   <= row_data.saturation;
            out_val_reg   <= row_data.value;
            out_adv_reg   <= adv;
            out_last_reg  <= (led_reg == LAST_LED);
        end
    end

    assign color.valid            = out_valid_reg;
    assign color.led_index        = out_index_reg;
    assign color.hue              = out_hue_reg;
    assign color.saturation       = out_sat_reg;
    assign color.brightness_value = out_val_reg;
    assign color.advanced         = out_adv_reg;
    assign color.last_of_frame    = out_last_reg;

endmodule

/* rtl/lpcs_checker.sv */
module lpcs_checker #(
    parameter int LED_COUNT = lpcs_pkg::LED_COUNT_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_ready,
    input logic       color_valid,
    input logic       color_ready,
    input logic [4:0] led_index,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] brightness_value,
    input logic       advanced,
    input logic       last_of_frame
);

    logic [6:0] expect_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_idx_reg <= '0;
        end
        else if (color_valid && color_ready)
        begin
            expect_idx_reg <= last_of_frame ? 7'd0 : 7'(expect_idx_reg + 7'd1);
        end
    end

    // stalled color transfer holds its payload
    a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !color_ready |=> color_valid
            && $stable({led_index, hue, saturation, brightness_value, advanced, last_of_frame}))
        else $error("color payload changed while stalled");

    // leds come out in order, one frame after another
    a_led_order: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> led_index == 5'(expect_idx_reg))
        else $error("led index out of sequence");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> last_of_frame == (expect_idx_reg == 7'(LED_COUNT - 1)))
        else $error("last_of_frame on wrong led");

    // no new tick while a frame is still being walked
    a_no_tick_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !last_of_frame |-> !tick_ready)
        else $error("tick accepted in the middle of a frame");

endmodule

bind led_pingpong_color_sequencer lpcs_checker #(
    .LED_COUNT (LED_COUNT)
) u_lpcs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_ready       (tick.ready),
    .color_valid      (color.valid),
    .color_ready      (color.ready),
    .led_index        (color.led_index),
    .hue              (color.hue),
    .saturation       (color.saturation),
    .brightness_value (color.brightness_value),
    .advanced         (color.advanced),
    .last_of_frame    (color.last_of_frame)
);
